// ===== rtl/core/fpsc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package fpsc_pkg;

  localparam logic [1:0] OP_LOAD    = 2'd0;
  localparam logic [1:0] OP_REBUILD = 2'd1;
  localparam logic [1:0] OP_TEST    = 2'd2;
  localparam logic [1:0] OP_IGNORED = 2'd3;

  localparam int NUM_PLANES = 6;

  typedef struct packed {
    logic [1:0]         op;
    logic [1:0]         matrix_column;
    logic [1:0]         matrix_row;
    logic signed [31:0] matrix_value;
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic signed [31:0] center_z;
    logic signed [31:0] sphere_radius;
  } in_item_t;

  typedef struct packed {
    logic inside_res;
  } out_item_t;

  // Request from the sequencer to the shared root/divide unit.
  typedef struct packed {
    logic        start;
    logic        is_sqrt;
    logic [67:0] operand;
    logic [63:0] divisor;
  } calc_req_t;

  typedef struct packed {
    logic        done;
    logic [67:0] result;
  } calc_rsp_t;

endpackage
`default_nettype wire

// ===== rtl/core/fpsc_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface fpsc_in_if;
  logic               valid;
  logic               ready;
  fpsc_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface fpsc_out_if;
  logic                valid;
  logic                ready;
  fpsc_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/frustum_plane_sphere_cull_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Channel  | Direction | Payload
// in       | sink      | op, matrix_column, matrix_row, matrix_value, center_x..z, sphere_radius
// out      | source    | inside_res
//
// A test reads the six stored planes through the plane memory, one plane (four
// words) per step: registered reads, then a multiply, a sum and a registered
// compare. A rebuild walks six planes; for each it reads eight matrix words,
// sums squares, runs a 34-step square root and, when the normal has nonzero
// length, four 68-step divisions in the shared calculation unit; else it
// stores zeros.
// Reset is synchronous and clears the usable mask, so stale plane memory
// contents are never tested; the matrix memory is cleared by valid bits.
// A result waits in the output register while the next transaction is taken;
// a test that finishes while that register is still full holds until it drains.
module frustum_plane_sphere_cull_top (
  input  wire logic   clk,
  input  wire logic   rst_n,
  fpsc_in_if.sink     in_ch,
  fpsc_out_if.source  out_ch
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MRD   = 4'd1;  // issue matrix read
  localparam logic [3:0] S_MCAP  = 4'd2;  // capture matrix word
  localparam logic [3:0] S_SQ    = 4'd3;  // accumulate squares
  localparam logic [3:0] S_SQRT  = 4'd4;
  localparam logic [3:0] S_DIV   = 4'd5;
  localparam logic [3:0] S_DWAIT = 4'd6;
  localparam logic [3:0] S_TRD   = 4'd7;  // test: read plane words
  localparam logic [3:0] S_TMUL  = 4'd8;
  localparam logic [3:0] S_TSUM  = 4'd9;
  localparam logic [3:0] S_TCMP  = 4'd10;
  localparam logic [3:0] S_OUT   = 4'd11;

  // Memories
  logic signed [31:0] mat_mem [16];
  logic [15:0]        mat_vld_r;
  logic signed [31:0] mat_rd_r;
  logic [3:0]         mat_ra;
  logic signed [31:0] pl_mem [24];
  logic signed [31:0] pl_rd_r;
  logic [4:0]         pl_ra;
  logic               pl_we;
  logic [4:0]         pl_wa;
  logic signed [31:0] pl_wd;

  logic [3:0]  st_r;
  logic [2:0]  pl_r;         // plane index
  logic [3:0]  wi_r;         // word step
  logic [5:0]  usable_r;
  logic signed [32:0] comp_r [4];
  logic signed [31:0] wtmp_r;
  logic [67:0] sumsq_r;
  logic [63:0] len_r;
  logic        issued_r;
  fpsc_pkg::in_item_t item_r;
  logic signed [31:0] pw_r [4];
  logic signed [63:0] prod_r [4];
  logic signed [65:0] dist_r;
  logic        rej_r;
  logic        out_vld_r;
  logic        out_bit_r;
  logic signed [32:0] cur;
  logic [32:0] cur_mag;
  logic [65:0] sq;
  fpsc_pkg::calc_req_t req;
  fpsc_pkg::calc_rsp_t rsp;
  logic [67:0] q;
  logic signed [32:0] plus_or_minus;
  logic signed [65:0] limit;

  fpsc_calc u_calc (.clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp));

  assign in_ch.ready = (st_r == S_IDLE);
  assign out_ch.valid = out_vld_r;
  assign out_ch.data.inside_res = out_bit_r;

  // Matrix read address: step wi_r even reads M(k,3), odd reads M(k,axis).
  assign mat_ra = wi_r[0] ? {wi_r[2:1], pl_r[2:1]} : {wi_r[2:1], 2'd3};
  assign pl_ra  = 5'({pl_r, 2'b00}) + 5'(wi_r[1:0]);

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready && in_ch.data.op == fpsc_pkg::OP_LOAD)
      mat_mem[{in_ch.data.matrix_column, in_ch.data.matrix_row}] <= in_ch.data.matrix_value;
    mat_rd_r <= mat_vld_r[mat_ra] ? mat_mem[mat_ra] : 32'sd0;
    if (pl_we) pl_mem[pl_wa] <= pl_wd;
    pl_rd_r <= pl_mem[pl_ra];
  end

  assign plus_or_minus = pl_r[0] ? (33'(wtmp_r) - 33'(mat_rd_r)) : (33'(wtmp_r) + 33'(mat_rd_r));
  assign cur     = comp_r[wi_r[1:0]];
  assign cur_mag = cur[32] ? 33'(-cur) : 33'(cur);
  assign sq      = cur_mag * cur_mag;
  assign q       = rsp.result;
  assign limit   = -(66'(item_r.sphere_radius) <<< 16);

  always_comb begin
    req = '0;
    pl_we = 1'b0;
    pl_wa = 5'({pl_r, 2'b00}) + 5'(wi_r[1:0]);
    pl_wd = '0;
    if (st_r == S_SQRT && !issued_r) begin
      req.start = 1'b1; req.is_sqrt = 1'b1; req.operand = sumsq_r;
    end
    if (st_r == S_DIV) begin
      if (len_r == 64'd0) begin
        pl_we = 1'b1;
      end else begin
        req.start = 1'b1;
        req.operand = {19'd0, cur_mag, 16'd0};
        req.divisor = len_r;
      end
    end
    if (st_r == S_DWAIT && rsp.done) begin
      pl_we = 1'b1;
      if (cur[32]) pl_wd = (q > 68'h80000000) ? 32'sh80000000 : 32'(-q);
      else         pl_wd = (q > 68'h7FFFFFFF) ? 32'sh7FFFFFFF : 32'(q);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; usable_r <= '0; mat_vld_r <= '0; out_vld_r <= 1'b0;
      issued_r <= 1'b0; pl_r <= '0; wi_r <= '0;
    end else begin
      if (out_vld_r && out_ch.ready) out_vld_r <= 1'b0;
      case (st_r)
        S_IDLE: if (in_ch.valid && in_ch.ready) begin
          item_r <= in_ch.data;
          pl_r <= '0; wi_r <= '0;
          case (in_ch.data.op)
            fpsc_pkg::OP_LOAD:
              mat_vld_r[{in_ch.data.matrix_column, in_ch.data.matrix_row}] <= 1'b1;
            fpsc_pkg::OP_REBUILD: begin st_r <= S_MRD; usable_r <= '0; end
            fpsc_pkg::OP_TEST: begin st_r <= S_TRD; rej_r <= 1'b0; end
            default: ;
          endcase
        end
        S_MRD: st_r <= S_MCAP;
        S_MCAP: begin
          if (!wi_r[0]) wtmp_r <= mat_rd_r;
          else comp_r[wi_r[2:1]] <= plus_or_minus;
          if (wi_r == 4'd7) begin
            wi_r <= '0; sumsq_r <= '0; st_r <= S_SQ;
          end else begin
            wi_r <= wi_r + 4'd1; st_r <= S_MRD;
          end
        end
        S_SQ: begin
          sumsq_r <= sumsq_r + 68'(sq);
          if (wi_r == 4'd2) begin wi_r <= '0; st_r <= S_SQRT; issued_r <= 1'b0; end
          else wi_r <= wi_r + 4'd1;
        end
        S_SQRT: begin
          if (issued_r && rsp.done) begin
            len_r <= 64'(q); st_r <= S_DIV; issued_r <= 1'b0;
            if (q != 68'd0) usable_r[pl_r] <= 1'b1;
          end else begin
            issued_r <= 1'b1;
          end
        end
        S_DIV: begin
          if (len_r == 64'd0) begin
            if (wi_r == 4'd3) begin
              wi_r <= '0;
              if (pl_r == 3'd5) st_r <= S_IDLE; else begin pl_r <= pl_r + 3'd1; st_r <= S_MRD; end
            end else wi_r <= wi_r + 4'd1;
          end else st_r <= S_DWAIT;
        end
        S_DWAIT: if (rsp.done) begin
          if (wi_r == 4'd3) begin
            wi_r <= '0;
            if (pl_r == 3'd5) st_r <= S_IDLE; else begin pl_r <= pl_r + 3'd1; st_r <= S_MRD; end
          end else begin wi_r <= wi_r + 4'd1; st_r <= S_DIV; end
        end
        S_TRD: begin
          // Address wi_r issued; data arrives next cycle.
          if (wi_r != 4'd0) pw_r[wi_r[1:0] - 2'd1] <= pl_rd_r;
          if (wi_r == 4'd4) begin wi_r <= '0; st_r <= S_TMUL; end
          else wi_r <= wi_r + 4'd1;
        end
        S_TMUL: begin
          prod_r[0] <= 64'(pw_r[0]) * 64'(item_r.center_x);
          prod_r[1] <= 64'(pw_r[1]) * 64'(item_r.center_y);
          prod_r[2] <= 64'(pw_r[2]) * 64'(item_r.center_z);
          prod_r[3] <= 64'(pw_r[3]) <<< 16;
          st_r <= S_TSUM;
        end
        S_TSUM: begin
          dist_r <= 66'(prod_r[0]) + 66'(prod_r[1]) + 66'(prod_r[2]) + 66'(prod_r[3]);
          st_r <= S_TCMP;
        end
        S_TCMP: begin
          if (usable_r[pl_r] && dist_r < limit) rej_r <= 1'b1;
          if (pl_r == 3'd5) st_r <= S_OUT;
          else begin pl_r <= pl_r + 3'd1; st_r <= S_TRD; end
        end
        S_OUT: begin
          // Wait here while the previous result still sits in the output register.
          if (!out_vld_r) begin
            out_vld_r <= 1'b1; out_bit_r <= !rej_r; st_r <= S_IDLE;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/fpsc_calc.sv =====
`timescale 1ns / 1ps
`default_nettype none
// One-bit-per-cycle unit: floor square root of a 68-bit value, or the
// unsigned quotient of a 68-bit dividend by a 64-bit divisor.
module fpsc_calc (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire fpsc_pkg::calc_req_t req,
  output fpsc_pkg::calc_rsp_t  rsp
);

  logic        busy_r, busy_nxt;
  logic        sqrt_r, sqrt_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic [67:0] num_r, num_nxt;
  logic [69:0] rem_r, rem_nxt;
  logic [67:0] q_r, q_nxt;
  logic [63:0] den_r, den_nxt;
  logic        done_r, done_nxt;
  logic [69:0] trial;
  logic [69:0] shifted;

  always_comb begin
    busy_nxt = busy_r;
    sqrt_nxt = sqrt_r;
    cnt_nxt  = cnt_r;
    num_nxt  = num_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    den_nxt  = den_r;
    done_nxt = 1'b0;
    shifted  = '0;
    trial    = '0;
    if (req.start) begin
      busy_nxt = 1'b1;
      sqrt_nxt = req.is_sqrt;
      num_nxt  = req.operand;
      den_nxt  = req.divisor;
      rem_nxt  = '0;
      q_nxt    = '0;
      cnt_nxt  = req.is_sqrt ? 7'd34 : 7'd68;
    end else if (busy_r) begin
      if (sqrt_r) begin
        // Restoring square root: two operand bits per step.
        shifted = {rem_r[67:0], num_r[67:66]};
        trial   = {q_r[67:0], 2'b01};
        num_nxt = {num_r[65:0], 2'b00};
      end else begin
        shifted = {rem_r[68:0], num_r[67]};
        trial   = {6'd0, den_r};
        num_nxt = {num_r[66:0], 1'b0};
      end
      if (shifted >= trial) begin
        rem_nxt = shifted - trial;
        q_nxt   = {q_r[66:0], 1'b1};
      end else begin
        rem_nxt = shifted;
        q_nxt   = {q_r[66:0], 1'b0};
      end
      cnt_nxt = cnt_r - 7'd1;
      if (cnt_r == 7'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    sqrt_r <= sqrt_nxt;
    num_r  <= num_nxt;
    rem_r  <= rem_nxt;
    q_r    <= q_nxt;
    den_r  <= den_nxt;
  end

  assign rsp.done   = done_r;
  assign rsp.result = q_r;

endmodule
`default_nettype wire

// ===== rtl/core/fpsc_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
module fpsc_assert (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic out_bit
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_bit)) else $error("out stall");
  a_accept_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !out_valid |=> !out_valid) else $error("result too early");
  a_out_known: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !$isunknown(out_bit)) else $error("unknown result");
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid) else $error("output after reset");
endmodule

bind frustum_plane_sphere_cull_top fpsc_assert u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_bit(out_ch.data.inside_res));
`default_nettype wire

// ===== sim/fpsc_checker.sv =====
`timescale 1ns / 1ps
// Watches both channels of the frustum culler, keeps its own copy of the
// matrix and plane state, and compares every sphere verdict in order.
module fpsc_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  fpsc_pkg::in_item_t            in_data,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  fpsc_pkg::out_item_t           out_data,
  output int                            fail_count,
  output int                            verdicts_pending
);

  logic signed [31:0] view_proj [16];
  logic signed [31:0] plane_coef [24];
  logic [fpsc_pkg::NUM_PLANES-1:0] plane_live;
  logic inside_queue [$];

  function automatic logic [33:0] root_floor(logic [67:0] s);
    logic [33:0] r;
    logic [33:0] t;
    logic [69:0] sq;
    r = '0;
    for (int b = 33; b >= 0; b--) begin
      t = r | (34'd1 << b);
      sq = 70'(t) * 70'(t);
      if (sq <= {2'b00, s}) r = t;
    end
    return r;
  endfunction

  // Component scaled by 1/len, truncated toward zero, then saturated.
  function automatic logic signed [31:0] scale_component(longint c, logic [33:0] len);
    logic [63:0] m;
    logic [63:0] q;
    m = (c < 0) ? 64'(-c) : 64'(c);
    q = (m << 16) / {30'd0, len};
    if (c < 0) begin
      if (q > 64'h8000_0000) q = 64'h8000_0000;
      return 32'(-q);
    end
    if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
    return 32'(q);
  endfunction

  task automatic extract_planes();
    longint comp [4];
    logic [67:0] sumsq;
    logic [63:0] m;
    logic [33:0] len;
    int axis;
    plane_live = '0;
    for (int p = 0; p < fpsc_pkg::NUM_PLANES; p++) begin
      axis = p >> 1;
      for (int k = 0; k < 4; k++)
        comp[k] = (p & 1) ? longint'(view_proj[k*4+3]) - longint'(view_proj[k*4+axis])
                          : longint'(view_proj[k*4+3]) + longint'(view_proj[k*4+axis]);
      sumsq = '0;
      for (int k = 0; k < 3; k++) begin
        m = (comp[k] < 0) ? 64'(-comp[k]) : 64'(comp[k]);
        sumsq += 68'(m) * 68'(m);
      end
      len = root_floor(sumsq);
      for (int k = 0; k < 4; k++)
        plane_coef[p*4+k] = (len != 0) ? scale_component(comp[k], len) : '0;
      if (len != 0) plane_live[p] = 1'b1;
    end
  endtask

  function automatic logic sphere_inside(fpsc_pkg::in_item_t it);
    logic signed [67:0] distance;
    logic signed [67:0] lim;
    logic signed [67:0] rad;
    rad = it.sphere_radius;
    lim = -(rad * 68'sd65536);
    for (int p = 0; p < fpsc_pkg::NUM_PLANES; p++) begin
      if (plane_live[p]) begin
        distance = 68'(plane_coef[p*4]) * 68'(it.center_x)
                 + 68'(plane_coef[p*4+1]) * 68'(it.center_y)
                 + 68'(plane_coef[p*4+2]) * 68'(it.center_z)
                 + 68'(plane_coef[p*4+3]) * 68'sd65536;
        if (distance < lim) return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  assign verdicts_pending = inside_queue.size();

  initial begin
    fail_count = 0;
    plane_live = '0;
    for (int i = 0; i < 16; i++) view_proj[i] = '0;
    for (int i = 0; i < 24; i++) plane_coef[i] = '0;
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      case (in_data.op)
        fpsc_pkg::OP_LOAD:    view_proj[{in_data.matrix_column, in_data.matrix_row}] =
                                in_data.matrix_value;
        fpsc_pkg::OP_REBUILD: extract_planes();
        fpsc_pkg::OP_TEST:    inside_queue.push_back(sphere_inside(in_data));
        default: ;
      endcase
    end
    if (rst_n && out_valid && out_ready) begin
      if (inside_queue.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("mismatch: unexpected result inside_res=%0b", out_data.inside_res);
      end else begin
        if (out_data.inside_res !== inside_queue[0]) begin
          fail_count++;
          if (fail_count <= 10)
            $display("mismatch: inside_res expected %0b got %0b",
                     inside_queue[0], out_data.inside_res);
        end
        void'(inside_queue.pop_front());
      end
    end
  end
endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// Testbench for the frustum plane extraction and sphere culling block.
// The top only makes stimulus and gives the verdict; all prediction and
// comparison live in the checker that sits beside the block.
module tb;

  localparam int ONE = 65536;
  localparam int IN_W = $bits(fpsc_pkg::in_item_t);

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   fail_count;
  int   verdicts_pending;

  // Requests for a long receiver hold-off; the receiver serves each in turn.
  int   hold_asked = 0;
  int   hold_served = 0;
  bit   drained = 1'b0;

  fpsc_in_if  in_ch ();
  fpsc_out_if out_ch ();

  frustum_plane_sphere_cull_top uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  fpsc_checker chk (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_ch.valid),
    .in_ready         (in_ch.ready),
    .in_data          (in_ch.data),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .out_data         (out_ch.data),
    .fail_count       (fail_count),
    .verdicts_pending (verdicts_pending)
  );

  always #5 clk = ~clk;

  // Hard stop in case the block hangs.
  initial begin
    #10ms;
    $display("status: fail");
    $finish;
  end

  // Receiver: stall density steps through four levels in turn, from never stalling
  // to stalling most of the time. A long hold-off is served when requested.
  int rx_cycle = 0;
  int rx_hold = 0;
  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 1;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (rx_hold > 0) begin
      rx_hold <= rx_hold - 1;
      out_ch.ready <= 1'b0;
    end else if (hold_served < hold_asked) begin
      hold_served <= hold_served + 1;
      rx_hold <= 400;
      out_ch.ready <= 1'b0;
    end else begin
      case ((rx_cycle / 128) % 4)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= ($urandom_range(0, 3) != 0);
        2: out_ch.ready <= ($urandom_range(0, 1) != 0);
        default: out_ch.ready <= ($urandom_range(0, 4) == 0);
      endcase
    end
  end

  // Sender bursts: a burst of random length, then a random gap. Zero-length
  // gaps are common so that back-to-back transactions also occur.
  int burst_left = 0;

  task automatic send_item(fpsc_pkg::in_item_t it);
    in_ch.data  <= it;
    in_ch.valid <= 1'b1;
    // Ready is stable between the falling edge and the next rising edge.
    forever begin
      @(negedge clk);
      if (in_ch.ready) break;
    end
    @(posedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 20);
      if ($urandom_range(0, 2) != 0) begin
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
  endtask

  // Mostly moderate values in a few units, sometimes extremes or raw bits.
  function automatic logic signed [31:0] pick_word();
    case ($urandom_range(0, 9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2, 3: return $urandom;
      4: return 32'($urandom_range(0, 2 * ONE)) - ONE;
      default: return 32'($urandom_range(0, 8 * ONE)) - 4 * ONE;
    endcase
  endfunction

  function automatic fpsc_pkg::in_item_t noise_item(logic [1:0] op);
    fpsc_pkg::in_item_t it;
    it = IN_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
    it.op = op;
    return it;
  endfunction

  task automatic load_entry(int col, int row, logic signed [31:0] v);
    fpsc_pkg::in_item_t it;
    it = noise_item(fpsc_pkg::OP_LOAD);
    it.matrix_column = 2'(col);
    it.matrix_row = 2'(row);
    it.matrix_value = v;
    send_item(it);
  endtask

  task automatic test_sphere(logic signed [31:0] x, logic signed [31:0] y,
                             logic signed [31:0] z, logic signed [31:0] r);
    fpsc_pkg::in_item_t it;
    it = noise_item(fpsc_pkg::OP_TEST);
    it.center_x = x;
    it.center_y = y;
    it.center_z = z;
    it.sphere_radius = r;
    send_item(it);
  endtask

  int sent;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data  = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. With no planes built every sphere is inside.
    test_sphere(32'h8000_0000, 32'h7FFF_FFFF, 0, 32'h8000_0000);
    // An unused opcode is ignored and gives no transaction on the output.
    send_item(noise_item(fpsc_pkg::OP_IGNORED));
    // Identity matrix: the unit cube bounded by planes at +-1.
    for (int i = 0; i < 4; i++) load_entry(i, i, ONE);
    send_item(noise_item(fpsc_pkg::OP_REBUILD));
    test_sphere(0, 0, 0, 0);
    test_sphere(2 * ONE, 0, 0, 0);
    test_sphere(2 * ONE, 0, 0, 2 * ONE);
    // A negative radius shrinks the sphere and rejects more readily.
    test_sphere(0, 0, 0, -ONE / 2);
    test_sphere(0, 0, 0, -2 * ONE);
    test_sphere(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    // Huge translation against a tiny normal drives d into saturation. Zeroing
    // entry (1,1) leaves the bottom and top normals empty.
    load_entry(0, 0, 1);
    load_entry(3, 3, 32'h7FFF_FFFF);
    load_entry(3, 0, 32'h8000_0000);
    load_entry(1, 1, 0);
    send_item(noise_item(fpsc_pkg::OP_REBUILD));
    test_sphere(0, 0, 0, 0);
    test_sphere(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0);
    test_sphere(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
    load_entry(0, 0, 0);
    load_entry(2, 2, 0);
    send_item(noise_item(fpsc_pkg::OP_REBUILD));
    test_sphere(5 * ONE, -7 * ONE, 0, 0);

    // Random part: mostly a full matrix, a rebuild, then a run of tests,
    // with stray loads and unused opcodes mixed in.
    sent = 0;
    while (sent < 680) begin
      if ($urandom_range(0, 4) != 0) begin
        for (int c = 0; c < 4; c++)
          for (int r = 0; r < 4; r++)
            load_entry(c, r, pick_word());
        send_item(noise_item(fpsc_pkg::OP_REBUILD));
        sent += 17;
      end
      repeat ($urandom_range(20, 50)) begin
        case ($urandom_range(0, 19))
          0: load_entry($urandom_range(0, 3), $urandom_range(0, 3), pick_word());
          1: send_item(noise_item(fpsc_pkg::OP_IGNORED));
          default: test_sphere(pick_word(), pick_word(), pick_word(), pick_word());
        endcase
        sent++;
        // Back-pressure: stall the receiver for a long stretch while the
        // sender keeps offering transactions.
        if (sent >= 300 && hold_asked == 0) hold_asked = hold_asked + 1;
        // Later, let the block drain completely before going on.
        if (sent >= 500 && !drained) begin
          drained = 1'b1;
          in_ch.valid <= 1'b0;
          burst_left = 0;
          while (verdicts_pending != 0) @(posedge clk);
        end
      end
    end

    in_ch.valid <= 1'b0;
    while (verdicts_pending != 0) @(posedge clk);
    // A trailing rebuild gives no result but may still be in progress.
    repeat (3000) @(posedge clk);
    if (fail_count == 0 && verdicts_pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
